/* sv/sva_pkg.sv */
// ----------------------------------------------------------------------------
// sva_pkg: shared types and constants for the synth voice allocator
// Field widths, operation and status codes, and the default voice count.
// ----------------------------------------------------------------------------
package sva_pkg;

	// Field widths
	localparam int KEY_W     = 16;
	localparam int VOICE_W   = 4;
	localparam int STATUS_W  = 2;
	localparam int OUT_DATA_W = 8;

	// Default pool size (1 to 15 voices fit VOICE_W)
	localparam int DEFAULT_VOICE_COUNT = 10;

	// Key event kind
	typedef enum logic [0:0] {
		OP_PRESS   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result status
	typedef enum logic [STATUS_W-1:0] {
		ST_ASSIGNED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_RELEASED = 2'd2,
		ST_NOT_HELD = 2'd3
	} status_t;

endpackage

/* sv/synth_voice_allocator_unit.sv */
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit: polyphonic voice allocator
// Hands out voices from a free queue on key presses and takes them back on
// key releases, one result per key event.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one key event per request. tuser[0] = operation
//   (0 press, 1 release), tdata[15:0] = key number.
//   Master stream: one result per event. tuser[1:0] = status
//   (0 assigned, 1 dropped, 2 released, 3 not held), tdata[3:0] = voice.
//   An accepted event passes through the input register, then the result
//   register. Throughput: one event per cycle while results are taken;
//   the key lookup is a parallel compare against all held keys and the
//   queue pointers move in the same cycle, so that cycle sets the rate.
//   Reset: the free queue holds all voices, handed out from the highest
//   index down; no key is held; both streams are empty.
//   Stall: while the result is not taken, the pending event waits in the
//   input register and s_axis_tready falls once that register is full.
//   A second press of a held key moves it to a new voice; the old voice
//   stays out of the pool until reset.
// ----------------------------------------------------------------------------
module synth_voice_allocator_unit #(
	parameter int VOICE_COUNT = sva_pkg::DEFAULT_VOICE_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sva_pkg::KEY_W-1:0]       s_axis_tdata,   // [15:0] key_number
	input  logic                            s_axis_tuser,   // [0] operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sva_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [3:0] voice_index, rest zero
	output logic [sva_pkg::STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

	localparam int PTR_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(VOICE_COUNT - 1);
	localparam logic [sva_pkg::VOICE_W-1:0] FULL_COUNT = sva_pkg::VOICE_W'(VOICE_COUNT);

	// Input register
	logic                        valid_s1;
	sva_pkg::op_t                op_s1;
	logic [sva_pkg::KEY_W-1:0]   key_s1;

	// Allocator state
	logic [sva_pkg::VOICE_W-1:0] free_queue_q [VOICE_COUNT];
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [sva_pkg::VOICE_W-1:0] free_count_q;
	logic [sva_pkg::KEY_W-1:0]   held_key_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0]      held_valid_q;

	// Result register
	logic                        m_valid_q;
	sva_pkg::status_t            status_q;
	logic [sva_pkg::VOICE_W-1:0] voice_q;

	// Per-item logic
	logic                        advance;
	logic [VOICE_COUNT-1:0]      hit;
	logic                        found;
	logic [PTR_W-1:0]            old_idx;
	logic [sva_pkg::VOICE_W-1:0] head_voice;
	logic [PTR_W-1:0]            new_idx;
	logic [PTR_W-1:0]            head_next;
	logic [PTR_W-1:0]            tail_next;
	logic                        do_take;
	logic                        do_clear;
	logic                        do_return;
	sva_pkg::status_t            status_d;
	logic [sva_pkg::VOICE_W-1:0] voice_d;

	// Handshake: stage 1 moves when the result register is free or being drained
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1  <= sva_pkg::op_t'(s_axis_tuser);
			key_s1 <= s_axis_tdata;
		end
	end

	// Parallel key lookup, lowest matching voice wins
	always_comb begin
		found   = 1'b0;
		old_idx = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			hit[v] = held_valid_q[v] && (held_key_q[v] == key_s1);
		end
		for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
			if (hit[v]) begin
				found   = 1'b1;
				old_idx = PTR_W'(v);
			end
		end
	end

	// Queue pointers and head voice
	assign head_voice = free_queue_q[head_q];
	assign new_idx    = head_voice[PTR_W-1:0];
	assign head_next  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_next  = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;

	// Decision for the item in stage 1
	always_comb begin
		do_take   = 1'b0;
		do_clear  = 1'b0;
		do_return = 1'b0;
		status_d  = sva_pkg::ST_ASSIGNED;
		voice_d   = '0;
		case (op_s1)
			sva_pkg::OP_PRESS: begin
				if (free_count_q == '0) begin
					status_d = sva_pkg::ST_DROPPED;
				end else begin
					do_take  = 1'b1;
					do_clear = found;
					voice_d  = head_voice;
				end
			end
			sva_pkg::OP_RELEASE: begin
				if (!found) begin
					status_d = sva_pkg::ST_NOT_HELD;
				end else begin
					do_clear  = 1'b1;
					do_return = (free_count_q < FULL_COUNT);
					status_d  = sva_pkg::ST_RELEASED;
					voice_d   = sva_pkg::VOICE_W'(old_idx);
				end
			end
			default: begin
				status_d = sva_pkg::ST_NOT_HELD;
			end
		endcase
	end

	// Queue and mapping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICE_COUNT; i++) begin
				free_queue_q[i] <= sva_pkg::VOICE_W'(VOICE_COUNT - 1 - i);
			end
			head_q       <= '0;
			tail_q       <= '0;
			free_count_q <= FULL_COUNT;
			held_valid_q <= '0;
		end else if (advance) begin
			if (do_take) begin
				head_q       <= head_next;
				free_count_q <= free_count_q - 1'b1;
			end
			if (do_return) begin
				free_queue_q[tail_q] <= sva_pkg::VOICE_W'(old_idx);
				tail_q               <= tail_next;
				free_count_q         <= free_count_q + 1'b1;
			end
			if (do_clear) begin
				held_valid_q[old_idx] <= 1'b0;
			end
			if (do_take) begin
				held_valid_q[new_idx] <= 1'b1;
			end
		end
	end

	// Held keys, read only where valid
	always_ff @(posedge clk) begin
		if (advance && do_take) begin
			held_key_q[new_idx] <= key_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			voice_q  <= voice_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {{(sva_pkg::OUT_DATA_W - sva_pkg::VOICE_W){1'b0}}, voice_q};

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= FULL_COUNT)
		else $error("free count above pool size");

	a_pool_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(32'($countones(held_valid_q)) + 32'(free_count_q)) <= VOICE_COUNT)
		else $error("held plus free voices exceed pool size");

	a_voice_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (status_q == sva_pkg::ST_ASSIGNED || status_q == sva_pkg::ST_RELEASED)
		|-> voice_q < FULL_COUNT)
		else $error("result voice out of range");

	a_take_marks_held: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_take |=> held_valid_q[$past(new_idx)])
		else $error("assigned voice not marked held");

endmodule

/* bench/tb_synth_voice_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_synth_voice_allocator_unit: self-checking bench for the voice allocator
// Drives key press and release requests and keeps its own copy of the free
// voice queue and the key map. Every result is checked against the status and
// voice predicted for the oldest outstanding request. Random gaps are placed
// on both streams.
// ----------------------------------------------------------------------------
module tb_synth_voice_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VOICES      = sva_pkg::DEFAULT_VOICE_COUNT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 384;
	localparam int MAX_STRANDED = 4;

	typedef struct packed {
		sva_pkg::status_t status;
		logic [3:0]       voice;
	} voice_result_t;

	// Shadow of the voice pool plus the results still owed by the block
	class voice_pool_model;
		logic [3:0]    free_queue [VOICES];
		int            head;
		int            tail;
		int            free_count;
		logic [15:0]   held_key [VOICES];
		bit            held_valid [VOICES];
		int            stranded;
		int            mismatches;
		voice_result_t awaited [$];

		function new();
			for (int i = 0; i < VOICES; i++) begin
				free_queue[i] = 4'(VOICES - 1 - i);
				held_key[i]   = '0;
				held_valid[i] = 1'b0;
			end
			head       = 0;
			tail       = 0;
			free_count = VOICES;
			stranded   = 0;
			mismatches = 0;
		endfunction

		// Voice currently mapped to key, -1 if none
		function int find_voice(logic [15:0] key);
			for (int i = 0; i < VOICES; i++)
				if (held_valid[i] && held_key[i] == key)
					return i;
			return -1;
		endfunction

		function logic [15:0] unheld_key();
			logic [15:0] key;
			do
				key = 16'($urandom);
			while (find_voice(key) >= 0);
			return key;
		endfunction

		function bit pick_held(output logic [15:0] key);
			int idx [$];
			key = '0;
			for (int i = 0; i < VOICES; i++)
				if (held_valid[i])
					idx = {idx, i};
			if (idx.size() == 0)
				return 1'b0;
			key = held_key[idx[$urandom_range(idx.size() - 1)]];
			return 1'b1;
		endfunction

		// Update the pool for an accepted request and queue its result
		function void note_key_event(sva_pkg::op_t op, logic [15:0] key);
			voice_result_t r;
			int            hit;
			logic [3:0]    v;
			hit = find_voice(key);
			if (op == sva_pkg::OP_PRESS) begin
				if (free_count == 0) begin
					r = '{sva_pkg::ST_DROPPED, 4'd0};
				end else begin
					v          = free_queue[head];
					head       = (head == VOICES - 1) ? 0 : head + 1;
					free_count = free_count - 1;
					// repress: old voice loses its key and never comes back
					if (hit >= 0) begin
						held_valid[hit] = 1'b0;
						stranded++;
					end
					held_key[v]   = key;
					held_valid[v] = 1'b1;
					r = '{sva_pkg::ST_ASSIGNED, v};
				end
			end else if (hit < 0) begin
				r = '{sva_pkg::ST_NOT_HELD, 4'd0};
			end else begin
				held_valid[hit] = 1'b0;
				if (free_count < VOICES) begin
					free_queue[tail] = 4'(hit);
					tail       = (tail == VOICES - 1) ? 0 : tail + 1;
					free_count = free_count + 1;
				end
				r = '{sva_pkg::ST_RELEASED, 4'(hit)};
			end
			awaited = {awaited, r};
		endfunction

		function void check_voice_result(logic [sva_pkg::OUT_DATA_W-1:0] data,
				logic [sva_pkg::STATUS_W-1:0] user);
			voice_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none awaited: status %0d data %0h",
						$time, user, data);
				return;
			end
			want = awaited.pop_front();
			if (user !== want.status || data !== {4'b0, want.voice}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: status %0d voice %0h, expected %0d voice %0h",
						$time, user, data, want.status, want.voice);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [sva_pkg::KEY_W-1:0]       s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [sva_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic [sva_pkg::STATUS_W-1:0]    m_axis_tuser;

	voice_pool_model pool;
	int              tx_idle_pct;
	int              rx_idle_pct;
	int              cycle_count;

	synth_voice_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_synth_voice_allocator_unit: errors");
		$finish;
	end

	// Result side: check taken results, then pick next ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			pool.check_voice_result(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Present one request, with random gaps before it, until it is taken
	task automatic send_event(sva_pkg::op_t op, logic [15:0] key);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= key;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pool.note_key_event(op, key);
	endtask

	// Hold the request side quiet until every result is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pool.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Mostly legal play: press free keys, release held ones; some stray
	// releases and a few represses of held keys
	task automatic play_random(int count);
		sva_pkg::op_t op;
		logic [15:0]  key;
		int           roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				op  = sva_pkg::OP_RELEASE;
				key = pool.unheld_key();
			end else if (roll < 9 && pool.stranded < MAX_STRANDED && pool.pick_held(key)) begin
				op = sva_pkg::OP_PRESS;
			end else if (roll < 52 && pool.pick_held(key)) begin
				op = sva_pkg::OP_RELEASE;
			end else begin
				op  = sva_pkg::OP_PRESS;
				key = pool.unheld_key();
			end
			send_event(op, key);
		end
	endtask

	initial begin
		pool          = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = sva_pkg::OP_PRESS;
		m_axis_tready = 1'b0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: key extremes, stray releases, repress, pool exhaustion
		send_event(sva_pkg::OP_PRESS,   16'h0000);
		send_event(sva_pkg::OP_PRESS,   16'hFFFF);
		send_event(sva_pkg::OP_RELEASE, 16'h0000);
		send_event(sva_pkg::OP_RELEASE, 16'h0000);
		send_event(sva_pkg::OP_RELEASE, 16'h1234);
		send_event(sva_pkg::OP_PRESS,   16'hFFFF);
		send_event(sva_pkg::OP_PRESS,   16'hAAAA);
		send_event(sva_pkg::OP_PRESS,   16'h5555);
		send_event(sva_pkg::OP_PRESS,   16'h0001);
		send_event(sva_pkg::OP_PRESS,   16'h8000);
		send_event(sva_pkg::OP_PRESS,   16'h00FF);
		send_event(sva_pkg::OP_PRESS,   16'hFF00);
		send_event(sva_pkg::OP_PRESS,   16'h0F0F);
		send_event(sva_pkg::OP_PRESS,   16'hF0F0);
		send_event(sva_pkg::OP_PRESS,   16'h7FFF);
		send_event(sva_pkg::OP_RELEASE, 16'hFFFF);
		send_event(sva_pkg::OP_RELEASE, 16'h8000);
		send_event(sva_pkg::OP_RELEASE, 16'h5555);
		wait_drained();

		// Slow sender against a mostly stalled receiver
		tx_idle_pct = 14;
		rx_idle_pct = 78;
		play_random(PHASE_ITEMS);
		wait_drained();

		// Swapped
		tx_idle_pct = 78;
		rx_idle_pct = 14;
		play_random(PHASE_ITEMS);
		wait_drained();

		// Back to back
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		play_random(PHASE_ITEMS);
		wait_drained();
		repeat (8) @(posedge clk);

		if (pool.mismatches == 0 && pool.awaited.size() == 0)
			$display("tb_synth_voice_allocator_unit: clean");
		else
			$display("tb_synth_voice_allocator_unit: errors");
		$finish;
	end

endmodule

/* synth_voice_allocator_unit.f */
sv/sva_pkg.sv
sv/synth_voice_allocator_unit.sv
bench/tb_synth_voice_allocator_unit.sv
